>>> rtl/grid_atlas_first_fit_allocator_core_assert.svh
// Assertion macros for the grid atlas allocator.
// Both sample on aclk and stay quiet while aresetn is low.
`ifndef GRID_ATLAS_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define GRID_ATLAS_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define GATLAS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("grid atlas allocator: check failed");

// Next-cycle implication.
`define GATLAS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("grid atlas allocator: check failed");

`endif

>>> rtl/gatlas_pkg.sv
package gatlas_pkg;

    localparam int MAX_COLS     = 64;
    localparam int MAX_ROWS_DEF = 64;
    localparam int CELL_PX      = 32;
    localparam int CELL_SHIFT   = 5;

    localparam int PX_W   = 12;
    localparam int CELL_W = 8;
    localparam int GRID_W = 7;
    localparam int CNT_W  = 8;
    localparam int COL_W  = 6;
    localparam int ROW_W  = 6;
    localparam int CFG_DW = 32;
    localparam int CFG_AW = 3;

    // Register index, taken from paddr[2]
    localparam logic CFG_IDX_COLS = 1'b0;
    localparam logic CFG_IDX_ROWS = 1'b1;

    typedef logic [MAX_COLS-1:0] row_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_SHIFT,
        ST_FIND,
        ST_MARK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic sweep_start;
        logic sweep;
        logic wr_mode;
        logic fit_load;
        logic shift;
        logic take_x;
        logic next_row;
        logic res_zero;
        logic res_fail;
        logic res_hit;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic zero_req;
        logic too_big;
        logic sweep_done;
        logic shift_done;
        logic fit_any;
        logic next_row_ok;
        logic out_free;
    } dp_stat_t;

    // Pixels to whole cells, rounding up.
    function automatic logic [CELL_W-1:0] cells_for(input logic [PX_W-1:0] px);
        logic [PX_W:0] s;
        s = {1'b0, px} + (PX_W+1)'(CELL_PX - 1);
        return CELL_W'(s >> CELL_SHIFT);
    endfunction

    // Index of the lowest set bit, zero when none.
    function automatic logic [COL_W-1:0] lowest_set(input row_word_t v);
        logic [COL_W-1:0] idx;
        idx = '0;
        for (int i = MAX_COLS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = COL_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> rtl/gatlas_ram.sv
module gatlas_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/gatlas_ctrl.sv
module gatlas_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gatlas_pkg::dp_stat_t stat,
    output gatlas_pkg::dp_cmd_t  cmd
);

    import gatlas_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.zero_req) begin
                    cmd.res_zero = 1'b1;
                    state_next   = ST_DONE;
                end else if (stat.too_big) begin
                    cmd.res_fail = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.sweep_start = 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_done) begin
                    cmd.fit_load = 1'b1;
                    state_next   = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (stat.shift_done) begin
                    state_next = ST_FIND;
                end else begin
                    cmd.shift = 1'b1;
                end
            end
            ST_FIND: begin
                if (stat.fit_any) begin
                    cmd.take_x      = 1'b1;
                    cmd.sweep_start = 1'b1;
                    state_next      = ST_MARK;
                end else if (stat.next_row_ok) begin
                    cmd.next_row = 1'b1;
                    state_next   = ST_SCAN;
                end else begin
                    cmd.res_fail = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_MARK: begin
                cmd.sweep   = 1'b1;
                cmd.wr_mode = 1'b1;
                if (stat.sweep_done) begin
                    cmd.res_hit = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/gatlas_dp.sv
module gatlas_dp #(
    parameter int MAX_ROWS = gatlas_pkg::MAX_ROWS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [gatlas_pkg::PX_W-1:0]      s_image_width_px,
    input  logic [gatlas_pkg::PX_W-1:0]      s_image_height_px,
    input  logic [gatlas_pkg::GRID_W-1:0]    cols_in_use,
    input  logic [gatlas_pkg::GRID_W-1:0]    rows_in_use,
    input  gatlas_pkg::dp_cmd_t              cmd,
    output gatlas_pkg::dp_stat_t             stat,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_placed,
    output logic [gatlas_pkg::COL_W-1:0]     m_origin_col,
    output logic [gatlas_pkg::ROW_W-1:0]     m_origin_row
);

    import gatlas_pkg::*;

    localparam int AW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROWS_CAP = (MAX_ROWS > 127) ? 127 : MAX_ROWS;

    logic [CELL_W-1:0] ww_reg, hh_reg, k_reg;
    logic [GRID_W-1:0] cols_reg, rows_reg;
    logic [CNT_W-1:0]  y_reg, r_reg;
    logic [AW-1:0]     wa_reg;
    row_word_t         acc_reg, fit_reg;
    logic [COL_W-1:0]  x_reg;
    logic              pend_reg, rd_vld_reg;
    logic              row_valid_reg [MAX_ROWS];
    logic              res_placed_reg;
    logic [COL_W-1:0]  res_col_reg;
    logic [ROW_W-1:0]  res_row_reg;
    logic              m_valid_reg, m_placed_reg;
    logic [COL_W-1:0]  m_col_reg;
    logic [ROW_W-1:0]  m_row_reg;

    logic [GRID_W-1:0] cols_sat, rows_sat;
    logic [CNT_W-1:0]  y_end;
    logic              issue;
    logic [AW-1:0]     raddr;
    row_word_t         rdata, row_eff, span, col_mask;
    logic              we;
    logic [CNT_W:0]    next_end;

    assign cols_sat = (cols_in_use > GRID_W'(MAX_COLS)) ? GRID_W'(MAX_COLS) : cols_in_use;
    assign rows_sat = (rows_in_use > GRID_W'(ROWS_CAP)) ? GRID_W'(ROWS_CAP) : rows_in_use;

    assign y_end   = y_reg + hh_reg;
    assign issue   = cmd.sweep && (r_reg != y_end);
    assign raddr   = r_reg[AW-1:0];
    assign row_eff = rd_vld_reg ? rdata : '0;
    assign span    = (~({MAX_COLS{1'b1}} << ww_reg)) << x_reg;
    assign col_mask = ~({MAX_COLS{1'b1}} << cols_reg);
    assign we      = pend_reg && cmd.wr_mode;
    assign next_end = {1'b0, y_reg} + (CNT_W+1)'(1) + {1'b0, hh_reg};

    gatlas_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_map (
        .aclk  (aclk),
        .we    (we),
        .waddr (wa_reg),
        .wdata (row_eff | span),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign stat.zero_req    = (ww_reg == '0) || (hh_reg == '0);
    assign stat.too_big     = (ww_reg > {1'b0, cols_reg}) || (hh_reg > {1'b0, rows_reg});
    assign stat.sweep_done  = (r_reg == y_end) && !pend_reg;
    assign stat.shift_done  = (k_reg == ww_reg);
    assign stat.fit_any     = |fit_reg;
    assign stat.next_row_ok = next_end <= (CNT_W+1)'(rows_reg);
    assign stat.out_free    = !m_valid_reg || m_ready;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_ROWS; i++) begin
                row_valid_reg[i] <= 1'b0;
            end
        end else begin
            pend_reg <= issue;
            if (we) begin
                row_valid_reg[wa_reg] <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Search datapath
    always_ff @(posedge aclk) begin
        rd_vld_reg <= row_valid_reg[raddr];
        if (issue) begin
            r_reg  <= r_reg + CNT_W'(1);
            wa_reg <= raddr;
        end
        if (pend_reg && !cmd.wr_mode) begin
            acc_reg <= acc_reg | row_eff;
        end
        if (cmd.capture) begin
            ww_reg   <= cells_for(s_image_width_px);
            hh_reg   <= cells_for(s_image_height_px);
            cols_reg <= cols_sat;
            rows_reg <= rows_sat;
            y_reg    <= '0;
        end
        if (cmd.sweep_start) begin
            r_reg   <= y_reg;
            acc_reg <= '0;
        end
        if (cmd.next_row) begin
            y_reg   <= y_reg + CNT_W'(1);
            r_reg   <= y_reg + CNT_W'(1);
            acc_reg <= '0;
        end
        if (cmd.fit_load) begin
            fit_reg <= ~acc_reg & col_mask;
            k_reg   <= CELL_W'(1);
        end
        if (cmd.shift) begin
            fit_reg <= fit_reg & (fit_reg >> 1);
            k_reg   <= k_reg + CELL_W'(1);
        end
        if (cmd.take_x) begin
            x_reg <= lowest_set(fit_reg);
        end
        if (cmd.res_zero) begin
            res_placed_reg <= 1'b1;
            res_col_reg    <= '0;
            res_row_reg    <= '0;
        end
        if (cmd.res_fail) begin
            res_placed_reg <= 1'b0;
            res_col_reg    <= '0;
            res_row_reg    <= '0;
        end
        if (cmd.res_hit) begin
            res_placed_reg <= 1'b1;
            res_col_reg    <= x_reg;
            res_row_reg    <= y_reg[ROW_W-1:0];
        end
        if (cmd.out_load) begin
            m_placed_reg <= res_placed_reg;
            m_col_reg    <= res_col_reg;
            m_row_reg    <= res_row_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_placed     = m_placed_reg;
    assign m_origin_col = m_col_reg;
    assign m_origin_row = m_row_reg;

endmodule

>>> rtl/grid_atlas_first_fit_allocator_core.sv
// Grid texture-atlas allocator: first-fit placement on a bitmap of 32-pixel cells.
// Input channel (s_valid/s_ready): one word carries an image width and height in
// pixels; both are rounded up to whole cells. Result channel (m_valid/m_ready):
// one word per request with placed, origin_col and origin_row (origin zero on failure).
// APB port: register 0 = columns in use, register 1 = rows in use; write only while idle.
// Timing: one item at a time. For each candidate row tried, a request reads the hh map
// rows it would cover (one row per cycle from the map RAM), shifts for the run length
// ww and picks the origin; a hit then marks the winning rows (hh, ww in cells).
// Zero-sized or oversized requests finish without a scan. The row-per-cycle map read
// and the shift loop set the request time.
// Reset clears the occupancy map at once through per-row valid bits and restores
// both grid registers to 64.
// A finished result sits in an output register; the next request is accepted while it
// waits, but its own result holds in the result registers until the receiver takes the first.
`include "grid_atlas_first_fit_allocator_core_assert.svh"

module grid_atlas_first_fit_allocator_core #(
    parameter int MAX_ROWS = gatlas_pkg::MAX_ROWS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gatlas_pkg::PX_W-1:0]     s_image_width_px,
    input  logic [gatlas_pkg::PX_W-1:0]     s_image_height_px,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_placed,
    output logic [gatlas_pkg::COL_W-1:0]    m_origin_col,
    output logic [gatlas_pkg::ROW_W-1:0]    m_origin_row,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gatlas_pkg::CFG_AW-1:0]   paddr,
    input  logic [gatlas_pkg::CFG_DW-1:0]   pwdata,
    output logic [gatlas_pkg::CFG_DW-1:0]   prdata,
    output logic                            pready
);

    import gatlas_pkg::*;

    logic [GRID_W-1:0] cols_in_use_reg;
    logic [GRID_W-1:0] rows_in_use_reg;
    logic              cfg_wr;
    dp_cmd_t           cmd;
    dp_stat_t          stat;

    // Register file: decode on the word address bit, hold the low seven data bits.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_in_use_reg <= GRID_W'(MAX_COLS);
            rows_in_use_reg <= GRID_W'(64);
        end else if (cfg_wr) begin
            if (paddr[2] == CFG_IDX_COLS) begin
                cols_in_use_reg <= pwdata[GRID_W-1:0];
            end else begin
                rows_in_use_reg <= pwdata[GRID_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_ROWS) ? CFG_DW'(rows_in_use_reg)
                                                : CFG_DW'(cols_in_use_reg);

    // Sequencer: scan rows, shift for run length, pick origin, mark rows.
    gatlas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Map RAM, row accumulator, fit word and result registers.
    gatlas_dp #(
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_image_width_px  (s_image_width_px),
        .s_image_height_px (s_image_height_px),
        .cols_in_use       (cols_in_use_reg),
        .rows_in_use       (rows_in_use_reg),
        .cmd               (cmd),
        .stat              (stat),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_placed          (m_placed),
        .m_origin_col      (m_origin_col),
        .m_origin_row      (m_origin_row)
    );

    // One request in flight: after an accept the input side closes.
    `GATLAS_ASSERT_NXT(a_single_item, s_valid && s_ready, !s_ready)
    // A failed placement reports the zero origin.
    `GATLAS_ASSERT_IMP(a_fail_origin, m_valid && !m_placed,
        m_origin_col == '0 && m_origin_row == '0)
    // Loading a result always raises the output word.
    `GATLAS_ASSERT_NXT(a_load_shows, cmd.out_load, m_valid)

endmodule
